[rtl/core/ogru_pkg.sv]
// ogru_pkg: shared types and constants of the occupancy grid ray update block
// field widths, status and command codes, register map and reset values
// no dependencies
package ogru_pkg;

    localparam int COORD_W    = 24;
    localparam int CPM_W      = 16;
    localparam int MARGIN_W   = 6;
    localparam int HIT_W      = 4;
    localparam int IDX_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 16;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED = 2'd0,
        ST_HEIGHT  = 2'd1,
        ST_BORDER  = 2'd2,
        ST_READ    = 2'd3
    } status_t;

    localparam logic CMD_RAY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_CPM    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HMIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HMAX   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HIT    = 3'd4;

    typedef struct packed {
        logic [CPM_W-1:0]    cells_per_meter_q8;
        logic [COORD_W-1:0]  height_min;
        logic [COORD_W-1:0]  height_max;
        logic [MARGIN_W-1:0] border_margin;
        logic [HIT_W-1:0]    hit_weight;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cells_per_meter_q8: 16'd5120,
        height_min:         24'd0,
        height_max:         24'd3840,
        border_margin:      6'd5,
        hit_weight:         4'd3
    };

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] robot_x;
        logic [COORD_W-1:0] robot_z;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_height;
        logic [COORD_W-1:0] point_z;
        logic [IDX_W-1:0]   cell_row;
        logic [IDX_W-1:0]   cell_col;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [OUT_CNT_W-1:0] occupied_count;
        logic [OUT_CNT_W-1:0] visited_count;
    } result_t;

endpackage

[rtl/core/ogru_apb_regs.sv]
// ogru_apb_regs: apb register file holding the block configuration
// depends on ogru_pkg for the register map and the cfg_t struct
module ogru_apb_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ogru_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ogru_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ogru_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output ogru_pkg::cfg_t                   cfg
);
    import ogru_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_CPM:    cfg_next.cells_per_meter_q8 = pwdata[CPM_W-1:0];
                REG_HMIN:   cfg_next.height_min         = pwdata[COORD_W-1:0];
                REG_HMAX:   cfg_next.height_max         = pwdata[COORD_W-1:0];
                REG_MARGIN: cfg_next.border_margin      = pwdata[MARGIN_W-1:0];
                REG_HIT:    cfg_next.hit_weight         = pwdata[HIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CPM:    prdata = APB_DATA_W'(cfg_reg.cells_per_meter_q8);
            REG_HMIN:   prdata = APB_DATA_W'(cfg_reg.height_min);
            REG_HMAX:   prdata = APB_DATA_W'(cfg_reg.height_max);
            REG_MARGIN: prdata = APB_DATA_W'(cfg_reg.border_margin);
            REG_HIT:    prdata = APB_DATA_W'(cfg_reg.hit_weight);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/ogru_cell_map.sv]
// ogru_cell_map: world coordinate to grid cell, one registered multiply then clamp
// depends on ogru_pkg for coordinate and scale widths
module ogru_cell_map #(
    parameter int GRID_CELLS = 128
) (
    input  logic                                 aclk,
    input  logic [ogru_pkg::COORD_W-1:0]         coord,
    input  logic [ogru_pkg::CPM_W-1:0]           cpm,
    output logic [$clog2(GRID_CELLS)-1:0]        cell_idx
);
    import ogru_pkg::*;

    localparam int CELL_W = $clog2(GRID_CELLS);
    localparam int PROD_W = COORD_W + CPM_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int HI_W   = SUM_W - 16;
    localparam logic [SUM_W-1:0] HALF_Q16 = SUM_W'(GRID_CELLS / 2) << 16;
    localparam logic [HI_W-1:0]  HI_LAST  = HI_W'(GRID_CELLS - 1);

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [SUM_W-1:0]  sum;
    logic        [HI_W-1:0]   hi;

    assign prod_next = $signed(coord) * $signed({1'b0, cpm});

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign sum = {prod_reg[PROD_W-1], prod_reg} + HALF_Q16;
    assign hi  = sum[SUM_W-1:16];

    always_comb begin
        if (sum[SUM_W-1]) begin
            cell_idx = '0;
        end else if (hi > HI_LAST) begin
            cell_idx = CELL_W'(GRID_CELLS - 1);
        end else begin
            cell_idx = hi[CELL_W-1:0];
        end
    end

endmodule

[rtl/core/ogru_ctrl.sv]
// ogru_ctrl: sequencer, bresenham walker and counter memory with read-modify-write
// depends on ogru_pkg and ogru_cell_map
module ogru_ctrl #(
    parameter int GRID_CELLS = 128,
    parameter int COUNT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ogru_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  ogru_pkg::item_t   s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output ogru_pkg::result_t m_res
);
    import ogru_pkg::*;

    localparam int CELL_W = $clog2(GRID_CELLS);
    localparam int ADDR_W = 2 * CELL_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int WORD_W = 2 * COUNT_BITS;
    localparam int ERR_W  = CELL_W + 2;
    localparam int BORD_W = CELL_W + MARGIN_W;
    localparam int H_W    = COORD_W + 1;
    localparam int ROW_W  = CELL_W + IDX_W;
    localparam logic [2:0] MAP_LAST = 3'd4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_MAP    = 8'b0000_0100,
        S_BORDER = 8'b0000_1000,
        S_SETUP  = 8'b0001_0000,
        S_TRACE  = 8'b0010_0000,
        S_DRAIN  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    function automatic logic in_border(input logic [CELL_W-1:0] c,
                                       input logic [MARGIN_W-1:0] m);
        logic [BORD_W-1:0] cw;
        logic [BORD_W-1:0] mw;
        cw = BORD_W'(c);
        mw = BORD_W'(m);
        return (cw < mw) || ((cw + mw) >= BORD_W'(GRID_CELLS));
    endfunction

    function automatic logic [CELL_W-1:0] abs_diff(input logic [CELL_W-1:0] p,
                                                   input logic [CELL_W-1:0] q);
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+OUT_CNT_W-1:0] w;
        w = (COUNT_BITS + OUT_CNT_W)'(v);
        return w[OUT_CNT_W-1:0];
    endfunction

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    item_t item_reg, item_next;
    logic [2:0] map_idx_reg, map_idx_next;
    logic [CELL_W-1:0] rx_reg, rx_next, rz_reg, rz_next;
    logic [CELL_W-1:0] px_reg, px_next, pz_reg, pz_next;
    logic steep_reg, steep_next;
    logic [CELL_W-1:0] a1_reg, a1_next, b1_reg, b1_next;
    logic [CELL_W-1:0] a2_reg, a2_next, b2_reg, b2_next;
    logic [CELL_W-1:0] a_cur_reg, a_cur_next, a_end_reg, a_end_next;
    logic [CELL_W-1:0] b_cur_reg, b_cur_next;
    logic [CELL_W-1:0] da_reg, da_next, db_reg, db_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic bneg_reg, bneg_next;
    logic pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic pend_hit_reg, pend_hit_next;
    status_t res_status_reg, res_status_next;
    logic res_zero_reg, res_zero_next;
    logic m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    logic [WORD_W-1:0] ram_reg [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [COORD_W-1:0] coord_sel;
    logic [CELL_W-1:0] map_cell;
    logic s_fire, out_free;
    logic signed [H_W-1:0] h_val, h_min, h_max;
    logic [ROW_W-1:0] row_wide, col_wide;
    logic rd_in_range;
    logic [CELL_W-1:0] dx_abs, dz_abs;
    logic steep_c, swap_c, border_c;
    logic [CELL_W-1:0] b_start_c, b_end_c;
    logic [CELL_W-1:0] tr_row, tr_col;
    logic signed [ERR_W-1:0] err_dec;
    logic [COUNT_BITS-1:0] rd_occ, rd_vis, occ_new, vis_new;
    logic [COUNT_BITS:0] occ_add, vis_add, occ_sum, vis_sum;

    ogru_cell_map #(.GRID_CELLS(GRID_CELLS)) u_map (
        .aclk     (aclk),
        .coord    (coord_sel),
        .cpm      (cfg.cells_per_meter_q8),
        .cell_idx (map_cell)
    );

    always_comb begin
        case (map_idx_reg[1:0])
            2'd0:    coord_sel = item_reg.robot_x;
            2'd1:    coord_sel = item_reg.robot_z;
            2'd2:    coord_sel = item_reg.point_x;
            default: coord_sel = item_reg.point_z;
        endcase
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_res    = m_res_reg;

    assign h_val = -$signed({s_item.point_height[COORD_W-1], s_item.point_height});
    assign h_min = $signed({cfg.height_min[COORD_W-1], cfg.height_min});
    assign h_max = $signed({cfg.height_max[COORD_W-1], cfg.height_max});

    assign row_wide    = ROW_W'(s_item.cell_row);
    assign col_wide    = ROW_W'(s_item.cell_col);
    assign rd_in_range = (row_wide < ROW_W'(GRID_CELLS)) && (col_wide < ROW_W'(GRID_CELLS));

    assign dx_abs   = abs_diff(px_reg, rx_reg);
    assign dz_abs   = abs_diff(pz_reg, rz_reg);
    assign steep_c  = dz_abs > dx_abs;
    assign border_c = in_border(px_reg, cfg.border_margin) || in_border(pz_reg, cfg.border_margin)
                   || in_border(rx_reg, cfg.border_margin) || in_border(rz_reg, cfg.border_margin);
    assign swap_c    = a1_reg > a2_reg;
    assign b_start_c = swap_c ? b2_reg : b1_reg;
    assign b_end_c   = swap_c ? b1_reg : b2_reg;

    assign tr_row  = steep_reg ? b_cur_reg : a_cur_reg;
    assign tr_col  = steep_reg ? a_cur_reg : b_cur_reg;
    assign err_dec = err_reg - $signed({2'b00, db_reg});

    // counter update for the entry read in the previous cycle
    assign rd_occ  = rdata_reg[WORD_W-1:COUNT_BITS];
    assign rd_vis  = rdata_reg[COUNT_BITS-1:0];
    assign occ_add = pend_hit_reg ? (COUNT_BITS + 1)'(cfg.hit_weight) : '0;
    assign vis_add = occ_add + (COUNT_BITS + 1)'(1);
    assign occ_sum = {1'b0, rd_occ} + occ_add;
    assign vis_sum = {1'b0, rd_vis} + vis_add;
    assign occ_new = occ_sum[COUNT_BITS] ? COUNT_MAX : occ_sum[COUNT_BITS-1:0];
    assign vis_new = vis_sum[COUNT_BITS] ? COUNT_MAX : vis_sum[COUNT_BITS-1:0];

    always_comb begin
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = pend_valid_reg;
            mem_waddr = pend_addr_reg;
            mem_wdata = {occ_new, vis_new};
        end
    end

    always_comb begin
        if (state_reg == S_TRACE) begin
            mem_re    = 1'b1;
            mem_raddr = {tr_row, tr_col};
        end else begin
            mem_re    = s_fire && (s_item.cmd == CMD_READ);
            mem_raddr = {row_wide[CELL_W-1:0], col_wide[CELL_W-1:0]};
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        item_next       = item_reg;
        map_idx_next    = map_idx_reg;
        rx_next         = rx_reg;
        rz_next         = rz_reg;
        px_next         = px_reg;
        pz_next         = pz_reg;
        steep_next      = steep_reg;
        a1_next         = a1_reg;
        b1_next         = b1_reg;
        a2_next         = a2_reg;
        b2_next         = b2_reg;
        a_cur_next      = a_cur_reg;
        a_end_next      = a_end_reg;
        b_cur_next      = b_cur_reg;
        da_next         = da_reg;
        db_next         = db_reg;
        err_next        = err_reg;
        bneg_next       = bneg_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_hit_next   = pend_hit_reg;
        res_status_next = res_status_reg;
        res_zero_next   = res_zero_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_res_next      = m_res_reg;

        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    item_next = s_item;
                    if (s_item.cmd == CMD_READ) begin
                        res_status_next = ST_READ;
                        res_zero_next   = !rd_in_range;
                        state_next      = S_DONE;
                    end else if ((h_val < h_min) || (h_val > h_max)) begin
                        res_status_next = ST_HEIGHT;
                        res_zero_next   = 1'b1;
                        state_next      = S_DONE;
                    end else begin
                        map_idx_next = '0;
                        state_next   = S_MAP;
                    end
                end
            end
            S_MAP: begin
                map_idx_next = map_idx_reg + 3'd1;
                case (map_idx_reg)
                    3'd1:    rx_next = map_cell;
                    3'd2:    rz_next = map_cell;
                    3'd3:    px_next = map_cell;
                    3'd4:    pz_next = map_cell;
                    default: begin
                    end
                endcase
                if (map_idx_reg == MAP_LAST) begin
                    state_next = S_BORDER;
                end
            end
            S_BORDER: begin
                steep_next = steep_c;
                a1_next    = steep_c ? rz_reg : rx_reg;
                b1_next    = steep_c ? rx_reg : rz_reg;
                a2_next    = steep_c ? pz_reg : px_reg;
                b2_next    = steep_c ? px_reg : pz_reg;
                if (border_c) begin
                    res_status_next = ST_BORDER;
                    res_zero_next   = 1'b1;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                a_cur_next = swap_c ? a2_reg : a1_reg;
                a_end_next = swap_c ? a1_reg : a2_reg;
                b_cur_next = b_start_c;
                da_next    = swap_c ? (a1_reg - a2_reg) : (a2_reg - a1_reg);
                db_next    = abs_diff(b_start_c, b_end_c);
                bneg_next  = !(b_start_c < b_end_c);
                err_next   = $signed(ERR_W'(da_next >> 1));
                state_next = S_TRACE;
            end
            S_TRACE: begin
                pend_valid_next = 1'b1;
                pend_addr_next  = {tr_row, tr_col};
                pend_hit_next   = (tr_row == px_reg) && (tr_col == pz_reg);
                a_cur_next      = a_cur_reg + CELL_W'(1);
                if (err_dec < 0) begin
                    err_next   = err_dec + $signed({2'b00, da_reg});
                    b_cur_next = bneg_reg ? (b_cur_reg - CELL_W'(1)) : (b_cur_reg + CELL_W'(1));
                end else begin
                    err_next = err_dec;
                end
                if (a_cur_reg == a_end_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                res_status_next = ST_APPLIED;
                res_zero_next   = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_res_next.status     = res_status_reg;
                    m_res_next.occupied_count = res_zero_reg ? '0 : to_out(rd_occ);
                    m_res_next.visited_count  = res_zero_reg ? '0 : to_out(rd_vis);
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        map_idx_reg    <= map_idx_next;
        rx_reg         <= rx_next;
        rz_reg         <= rz_next;
        px_reg         <= px_next;
        pz_reg         <= pz_next;
        steep_reg      <= steep_next;
        a1_reg         <= a1_next;
        b1_reg         <= b1_next;
        a2_reg         <= a2_next;
        b2_reg         <= b2_next;
        a_cur_reg      <= a_cur_next;
        a_end_reg      <= a_end_next;
        b_cur_reg      <= b_cur_next;
        da_reg         <= da_next;
        db_reg         <= db_next;
        err_reg        <= err_next;
        bneg_reg       <= bneg_next;
        pend_addr_reg  <= pend_addr_next;
        pend_hit_reg   <= pend_hit_next;
        res_status_reg <= res_status_next;
        res_zero_reg   <= res_zero_next;
        m_res_reg      <= m_res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ram_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= ram_reg[mem_raddr];
        end
    end

    // a trace read never hits the entry whose write-back is in flight
    a_no_rmw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRACE) && pend_valid_reg |-> mem_raddr != pend_addr_reg)
        else $error("trace read overlaps pending write");

    a_trace_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRACE) |-> a_cur_reg <= a_end_reg)
        else $error("trace ran past its end");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside done state");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready && !pend_valid_reg)
        else $error("activity during clearing pass");

endmodule

[rtl/core/occupancy_grid_ray_update_top.sv]
// occupancy grid ray update, top level: stream ports, apb registers, controller
// read and height-rejected items go straight to a result, border-rejected ones after the
// cell mapping and border check, applied rays after tracing n cells (n up to GRID_CELLS),
// one memory read-modify-write per cell; the next item can be taken while a result is shown
// reset: synchronous active-low; afterwards a clearing pass over all 2^(2*clog2(GRID_CELLS))
// entries (16384 at 128 cells) zeroes the counters, items wait, apb writes are taken
module occupancy_grid_ray_update_top #(
    parameter int GRID_CELLS = 128,
    parameter int COUNT_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // robot_x, robot_z, point_x, point_height, point_z, cell_row, cell_col, zero pad
    input  logic [ogru_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // occupied_count, visited_count
    output logic [ogru_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [ogru_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ogru_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ogru_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ogru_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ogru_pkg::*;

    cfg_t    cfg;
    item_t   s_item;
    result_t m_res;

    always_comb begin
        s_item.cmd          = s_tuser[0];
        s_item.robot_x      = s_tdata[23:0];
        s_item.robot_z      = s_tdata[47:24];
        s_item.point_x      = s_tdata[71:48];
        s_item.point_height = s_tdata[95:72];
        s_item.point_z      = s_tdata[119:96];
        s_item.cell_row     = s_tdata[126:120];
        s_item.cell_col     = s_tdata[133:127];
    end

    assign m_tdata = {m_res.visited_count, m_res.occupied_count};
    assign m_tuser = m_res.status;

    ogru_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ogru_ctrl #(
        .GRID_CELLS (GRID_CELLS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

endmodule
